// ----- hw/rtl/qbez_pkg.sv -----
`timescale 1ns / 1ps

package qbez_pkg;

  // Configuration register file: five control points, three packed coordinates each.
  localparam int CFG_WIDTH  = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_POINTS = 5;

  // De Casteljau levels of the quartic; lower degrees reuse the same levels.
  localparam int NUM_LEVELS = 4;
  localparam int NUM_AXES   = 3;

  // Stream payload layout.
  localparam int T_IN_WIDTH  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_WIDTH   = 18;
  localparam int OUT_TDATA_W = 56;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Width of the partial-product slices of the wide multiplications.
  localparam int MUL_CHUNK = 32;

  typedef enum logic [1:0] {
    CMD_POSITION     = 2'd0,
    CMD_FIRST_DERIV  = 2'd1,
    CMD_SECOND_DERIV = 2'd2
  } cmd_t;

endpackage

// ----- hw/rtl/quartic_bezier_evaluator_top.sv -----
`timescale 1ns / 1ps

// Quartic Bezier evaluator: five 3D control points live in configuration registers 0..4,
// and every input beat (t_value in tdata, command in tuser) returns one output beat holding
// the position, the first difference curve or the second difference curve at t (all zero
// for the unused command), each component rounded to coordinate units and saturated to 18
// bits. The datapath is a ten stage pipeline: one input stage, a multiply stage and a sum
// stage for each of the four de Casteljau levels, and a rounding stage that is also the
// output register. A new beat is taken every cycle while the output side does not stall.
// The wide products of each level are built from 32-bit slices, which sets the depth of
// the multiply and sum stages. Lower-degree curves run through the same levels, with the
// leading levels only scaling by one.
module quartic_bezier_evaluator_top
  import qbez_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_WIDTH-1:0]   cfg_wdata,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] t_value
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [1:0] command
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [17:0] out_x, [35:18] out_y, [53:36] out_z
);

  localparam int W    = COORD_WIDTH;
  localparam int TF   = T_FRAC_BITS;
  localparam int BW   = TF + 1;
  localparam int PW   = W + 2;
  localparam int AW   = PW + NUM_LEVELS * TF;
  localparam int CH   = MUL_CHUNK;
  localparam int NC   = (AW + CH - 1) / CH;
  localparam int PPW  = CH + BW;
  localparam int EW   = (NUM_AXES * W > CFG_WIDTH) ? NUM_AXES * W : CFG_WIDTH;
  localparam int SH   = NUM_LEVELS * TF;
  localparam int RW   = AW + 1 - SH;
  localparam int XW   = (RW > OUT_WIDTH) ? RW : OUT_WIDTH;
  localparam int TCW  = (BW > T_IN_WIDTH) ? BW : T_IN_WIDTH;
  localparam int NST  = 2 * NUM_LEVELS + 2;
  localparam int NCTL = 2 * NUM_LEVELS - 1;

  localparam logic [BW-1:0]          S_VAL    = {1'b1, {TF{1'b0}}};
  localparam logic [AW:0]            HALF_RND = (AW + 1)'(1) << (SH - 1);
  localparam logic signed [XW-1:0]   LIM_HI   = XW'(OUT_MAX);
  localparam logic signed [XW-1:0]   LIM_LO   = XW'(OUT_MIN);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH-1:0] ctrl [NUM_POINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        ctrl[i] <= '0;
      end
    end else if (cfg_we && (cfg_addr < CFG_IDX_W'(NUM_POINTS))) begin
      ctrl[cfg_addr] <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v;
  logic [NST-1:0] rdy;

  assign rdy[NST-1] = !v[NST-1] || m_axis_tready;

  for (genvar k = 0; k < NST - 1; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v[NST-1];

  // ---------------------------------------------------------------------------
  // Input stage: clamp t, pick the control net for the command.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] pnt  [NUM_AXES][NUM_POINTS];
  logic signed [W:0]   dif1 [NUM_AXES][NUM_POINTS-1];
  logic signed [W+1:0] dif2 [NUM_AXES][NUM_POINTS-2];

  always_comb begin
    logic [EW-1:0] ext;
    for (int i = 0; i < NUM_POINTS; i++) begin
      ext = EW'(ctrl[i]);
      for (int a = 0; a < NUM_AXES; a++) begin
        pnt[a][i] = ext[a*W +: W];
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int i = 0; i < NUM_POINTS - 1; i++) begin
        dif1[a][i] = (W + 1)'(pnt[a][i+1]) - (W + 1)'(pnt[a][i]);
      end
      for (int i = 0; i < NUM_POINTS - 2; i++) begin
        dif2[a][i] = (W + 2)'(dif1[a][i+1]) - (W + 2)'(dif1[a][i]);
      end
    end
  end

  logic [AW-1:0]  net_in [NUM_AXES][NUM_POINTS];
  logic [1:0]     np_in;
  logic [TCW-1:0] t_ext;
  logic [BW-1:0]  t_in;
  logic [BW-1:0]  u_in;

  always_comb begin
    t_ext = TCW'(s_axis_tdata[T_IN_WIDTH-1:0]);
    t_in  = (t_ext > TCW'(S_VAL)) ? S_VAL : BW'(t_ext);
    u_in  = S_VAL - t_in;
  end

  // np counts the leading levels that only scale by S; a degree-n curve skips 4-n levels.
  always_comb begin
    net_in = '{default: '0};
    np_in  = 2'd0;
    unique case (cmd_t'(s_axis_tuser))
      CMD_POSITION: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          for (int i = 0; i < NUM_POINTS; i++) begin
            net_in[a][i] = AW'(pnt[a][i]);
          end
        end
      end
      CMD_FIRST_DERIV: begin
        np_in = 2'd1;
        for (int a = 0; a < NUM_AXES; a++) begin
          for (int i = 0; i < NUM_POINTS - 1; i++) begin
            net_in[a][i] = AW'(dif1[a][i]);
          end
        end
      end
      CMD_SECOND_DERIV: begin
        np_in = 2'd2;
        for (int a = 0; a < NUM_AXES; a++) begin
          for (int i = 0; i < NUM_POINTS - 2; i++) begin
            net_in[a][i] = AW'(dif2[a][i]);
          end
        end
      end
      default: begin
        np_in = 2'd0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // De Casteljau levels. Values are kept modulo 2^AW; every true intermediate
  // fits AW signed bits, so unsigned slice products give exact results.
  // ---------------------------------------------------------------------------
  logic [AW-1:0]  q_pl  [0:NUM_LEVELS][NUM_AXES][NUM_POINTS];
  logic [BW-1:0]  t_pl  [0:NCTL-1];
  logic [BW-1:0]  u_pl  [0:NCTL-1];
  logic [1:0]     np_pl [0:NCTL-1];

  logic [NC-1:0][PPW-1:0] pp_pl   [1:NUM_LEVELS][NUM_AXES][NUM_POINTS][2];
  logic [NC-1:0][PPW-1:0] pp_next [1:NUM_LEVELS][NUM_AXES][NUM_POINTS][2];
  logic [AW-1:0]          q_next  [1:NUM_LEVELS][NUM_AXES][NUM_POINTS];

  always_comb begin
    logic [BW-1:0]      mu;
    logic [BW-1:0]      mt;
    logic [NC*CH-1:0]   au;
    logic [NC*CH-1:0]   at;
    pp_next = '{default: '0};
    for (int lv = 1; lv <= NUM_LEVELS; lv++) begin
      if (lv > int'(np_pl[2*lv-2])) begin
        mu = u_pl[2*lv-2];
        mt = t_pl[2*lv-2];
      end else begin
        mu = S_VAL;
        mt = '0;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int nd = 0; nd < NUM_POINTS - lv; nd++) begin
          au = (NC * CH)'(q_pl[lv-1][a][nd]);
          at = (NC * CH)'(q_pl[lv-1][a][nd+1]);
          for (int j = 0; j < NC; j++) begin
            pp_next[lv][a][nd][0][j] = PPW'(au[j*CH +: CH]) * PPW'(mu);
            pp_next[lv][a][nd][1][j] = PPW'(at[j*CH +: CH]) * PPW'(mt);
          end
        end
      end
    end
  end

  always_comb begin
    q_next = '{default: '0};
    for (int lv = 1; lv <= NUM_LEVELS; lv++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int nd = 0; nd < NUM_POINTS - lv; nd++) begin
          for (int j = 0; j < NC; j++) begin
            q_next[lv][a][nd] = q_next[lv][a][nd]
                              + (AW'(pp_pl[lv][a][nd][0][j]) << (j * CH))
                              + (AW'(pp_pl[lv][a][nd][1][j]) << (j * CH));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Round to nearest (ties up) and saturate.
  // ---------------------------------------------------------------------------
  logic [NUM_AXES-1:0][OUT_WIDTH-1:0] res_next;

  always_comb begin
    logic signed [AW:0]   rsum;
    logic signed [AW:0]   rsh;
    logic signed [XW-1:0] rx;
    for (int a = 0; a < NUM_AXES; a++) begin
      rsum = (AW + 1)'($signed(q_pl[NUM_LEVELS][a][0])) + $signed(HALF_RND);
      rsh  = rsum >>> SH;
      rx   = XW'($signed(rsh[RW-1:0]));
      if (rx > LIM_HI) begin
        rx = LIM_HI;
      end else if (rx < LIM_LO) begin
        rx = LIM_LO;
      end
      res_next[a] = rx[OUT_WIDTH-1:0];
    end
  end

  logic [NUM_AXES-1:0][OUT_WIDTH-1:0] res;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      q_pl[0]  <= net_in;
      t_pl[0]  <= t_in;
      u_pl[0]  <= u_in;
      np_pl[0] <= np_in;
    end
    for (int k = 1; k < NCTL; k++) begin
      if (rdy[k]) begin
        t_pl[k]  <= t_pl[k-1];
        u_pl[k]  <= u_pl[k-1];
        np_pl[k] <= np_pl[k-1];
      end
    end
    for (int lv = 1; lv <= NUM_LEVELS; lv++) begin
      if (rdy[2*lv-1]) begin
        pp_pl[lv] <= pp_next[lv];
      end
      if (rdy[2*lv]) begin
        q_pl[lv] <= q_next[lv];
      end
    end
    if (rdy[NST-1]) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(res);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NST; k++) begin : g_hold
    a_stage_hold: assert property (@(posedge clk) disable iff (rst)
      v[k] && !rdy[k] |=> v[k])
      else $error("pipeline stage %0d lost a beat while stalled", k);
  end

  a_np_range: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> (np_pl[0] != 2'd3))
    else $error("input stage holds an impossible scaling count");

  a_scale_only: assert property (@(posedge clk) disable iff (rst)
    v[0] && rdy[1] && (np_pl[0] != 2'd0) |=> (pp_pl[1][0][0][1] == '0))
    else $error("scaling level mixed in the t term");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");

endmodule

// ----- test/quartic_bezier_evaluator_top_test.sv -----
`timescale 1ns / 1ps

module quartic_bezier_evaluator_top_test;
  import qbez_pkg::*;

  localparam int COORD_W = 16;
  localparam int T_FRAC = 15;
  localparam int T_ONE = 1 << T_FRAC;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_REGS = 1 << CFG_IDX_W;
  localparam int PHASE_ITEMS = 150;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] t;
  } sample_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] z;
    logic [OUT_WIDTH-1:0] y;
    logic [OUT_WIDTH-1:0] x;
  } point_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_WIDTH-1:0]   cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [CFG_WIDTH-1:0] ctrl_model [NUM_POINTS];
  sample_t              pending_samples[$];
  point_out_t           expected_points[$];
  sample_t              next_sample;
  point_out_t           got_point;
  int                   mismatches = 0;
  int                   src_gap = 0;
  int                   snk_gap = 0;
  bit                   src_quiet = 1'b0;
  bit                   snk_quiet = 1'b0;

  quartic_bezier_evaluator_top #(
    .COORD_WIDTH(COORD_W),
    .T_FRAC_BITS(T_FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Position, first or second difference curve at t, per axis, in exact wide arithmetic.
  function automatic point_out_t predict_point(logic [1:0] cmd, logic [15:0] t_raw);
    point_out_t res;
    logic signed [127:0] q [NUM_POINTS];
    logic signed [127:0] t_s, u_s, acc;
    logic signed [COORD_W-1:0] coord;
    int deg;
    res = '0;
    case (cmd)
      CMD_POSITION:     deg = 4;
      CMD_FIRST_DERIV:  deg = 3;
      CMD_SECOND_DERIV: deg = 2;
      default:          deg = 0;
    endcase
    if (deg == 0) return res;
    t_s = (t_raw > T_ONE) ? T_ONE : t_raw;
    u_s = T_ONE - t_s;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        coord = ctrl_model[i][ax*COORD_W +: COORD_W];
        q[i] = coord;
      end
      // Derivative commands work on the difference polygons.
      for (int lv = NUM_LEVELS; lv > deg; lv--)
        for (int i = 0; i < lv; i++)
          q[i] = q[i+1] - q[i];
      for (int lv = 1; lv <= deg; lv++)
        for (int i = 0; i + lv <= deg; i++)
          q[i] = q[i] * u_s + q[i+1] * t_s;
      acc = (q[0] + (128'sd1 <<< (deg * T_FRAC - 1))) >>> (deg * T_FRAC);
      if (acc > OUT_MAX) acc = OUT_MAX;
      else if (acc < OUT_MIN) acc = OUT_MIN;
      case (ax)
        0: res.x = acc[OUT_WIDTH-1:0];
        1: res.y = acc[OUT_WIDTH-1:0];
        default: res.z = acc[OUT_WIDTH-1:0];
      endcase
    end
    return res;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_t();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      case ($urandom_range(0, 3))
        0: return 16'd0;
        1: return 16'd1;
        2: return 16'(T_ONE - 1);
        default: return 16'(T_ONE);
      endcase
    end
    if (sel < 80) return 16'($urandom_range(0, T_ONE));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [1:0] rand_cmd();
    if ($urandom_range(0, 9) == 0) return CMD_UNUSED;
    return 2'($urandom_range(CMD_POSITION, CMD_SECOND_DERIV));
  endfunction

  // kind 0: any value, 1: extremes, 2: near zero, 3: a mix of those per coordinate.
  function automatic logic [COORD_W-1:0] rand_coord(int kind);
    if (kind == 3) kind = $urandom_range(0, 2);
    case (kind)
      0: return 16'($urandom_range(0, 16'hFFFF));
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 16)) - 16'd8;
    endcase
  endfunction

  task automatic write_reg(input int idx, input logic [CFG_WIDTH-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx[CFG_IDX_W-1:0];
    cfg_wdata <= value;
    if (idx < NUM_POINTS) ctrl_model[idx] = value;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_points(input int kind);
    logic [CFG_WIDTH-1:0] word;
    for (int i = 0; i < NUM_POINTS; i++) begin
      word = {rand_coord(kind), rand_coord(kind), rand_coord(kind)};
      write_reg(i, word);
    end
    // Indexes past the last point must leave the points alone.
    if ($urandom_range(0, 1))
      write_reg($urandom_range(NUM_POINTS, NUM_REGS - 1), CFG_WIDTH'({$urandom, $urandom}));
    end_writes();
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    while ((pending_samples.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
           && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_points.size() != 0) begin
      report($sformatf("%0d results never arrived", expected_points.size()));
      expected_points.delete();
    end
  endtask

  task automatic queue_sample(input logic [1:0] cmd, input logic [15:0] t);
    sample_t smp;
    smp.cmd = cmd;
    smp.t = t;
    pending_samples = {pending_samples, smp};
  endtask

  // Source side: a beat is offered until taken, then an optional gap.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_points = {expected_points, predict_point(s_axis_tuser, s_axis_tdata)};
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_sample = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_sample.t;
          s_axis_tuser <= next_sample.cmd;
          if (!src_quiet && $urandom_range(0, 2) == 0) src_gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: check every beat against the oldest prediction, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_points.size() == 0) begin
          report($sformatf("result %h with no sample outstanding", m_axis_tdata));
        end else begin
          got_point = expected_points.pop_front();
          if (m_axis_tdata[OUT_WIDTH-1:0] !== got_point.x)
            report($sformatf("out_x %h, expected %h", m_axis_tdata[OUT_WIDTH-1:0],
                             got_point.x));
          if (m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH] !== got_point.y)
            report($sformatf("out_y %h, expected %h", m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH],
                             got_point.y));
          if (m_axis_tdata[3*OUT_WIDTH-1:2*OUT_WIDTH] !== got_point.z)
            report($sformatf("out_z %h, expected %h",
                             m_axis_tdata[3*OUT_WIDTH-1:2*OUT_WIDTH], got_point.z));
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!snk_quiet && $urandom_range(0, 7) == 0) snk_gap <= pick_gap();
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_POINTS; i++) ctrl_model[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Points still at their reset value: every command yields zero.
    queue_sample(CMD_POSITION, 16'(T_ONE / 2));
    queue_sample(CMD_FIRST_DERIV, 16'(T_ONE / 2));
    queue_sample(CMD_SECOND_DERIV, 16'(T_ONE / 2));
    queue_sample(CMD_UNUSED, 16'(T_ONE / 2));
    wait_idle();

    // Alternating extreme points give the largest differences; the writes past the
    // last point are ignored.
    write_reg(0, {3{16'h7FFF}});
    write_reg(1, {3{16'h8000}});
    write_reg(2, {3{16'h7FFF}});
    write_reg(3, {3{16'h8000}});
    write_reg(4, {3{16'h7FFF}});
    write_reg(NUM_POINTS, {CFG_WIDTH{1'b1}});
    write_reg(NUM_REGS - 1, {CFG_WIDTH{1'b1}});
    end_writes();
    for (int c = CMD_POSITION; c <= CMD_UNUSED; c++) begin
      queue_sample(2'(c), 16'd0);
      queue_sample(2'(c), 16'd1);
      queue_sample(2'(c), 16'(T_ONE - 1));
      queue_sample(2'(c), 16'(T_ONE));
      queue_sample(2'(c), 16'hFFFF);
    end
    queue_sample(CMD_POSITION, 16'(T_ONE + 1));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      load_points(ph % 4);
      repeat (PHASE_ITEMS) queue_sample(rand_cmd(), rand_t());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
